[rtl/hndv_pkg.sv]
// Shared types, constants and codes for the hello neighbor distance vector table.
package hndv_pkg;

   localparam int unsigned HostWidth        = 48;
   localparam int unsigned CostWidth        = 8;
   localparam int unsigned OpWidth          = 3;
   localparam int unsigned TimeWidth        = 32;
   localparam int unsigned JoinWidth        = 16;
   localparam int unsigned TimeoutWidth     = 16;
   localparam int unsigned CountWidth       = 4;
   localparam int unsigned CsrIndexWidth    = 2;
   localparam int unsigned CsrDataWidth     = 48;
   localparam int unsigned DefMaxNeighbors  = 8;
   localparam int unsigned DefMaxRoutes     = 16;
   localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd40;
   localparam logic [CountWidth-1:0]   TargetReset  = 4'd2;
   localparam logic [CostWidth-1:0]    CostMax      = 8'd255;

   typedef enum logic [OpWidth-1:0] {
      OP_HEADER = 3'd0,
      OP_LISTED = 3'd1,
      OP_ROUTE  = 3'd2,
      OP_END    = 3'd3,
      OP_TICK   = 3'd4,
      OP_SEARCH = 3'd5,
      OP_QUERY  = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_THIS_HOST = 2'd0,
      CSR_TIMEOUT   = 2'd1,
      CSR_TARGET    = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COPY,
      ST_QUERY,
      ST_RESULT
   } state_type;

   // Request payload
   typedef struct packed {
      logic [OpWidth-1:0]    operation;
      logic [HostWidth-1:0]  host;
      logic [CostWidth-1:0]  cost;
   } req_type;

   // Response payload
   typedef struct packed {
      logic                  route_found;
      logic [HostWidth-1:0]  next_hop;
      logic [CostWidth-1:0]  route_cost;
      logic                  searching;
      logic [CountWidth-1:0] bidir_count;
      logic [CountWidth-1:0] unidir_count;
      logic                  need_neighbor;
      logic                  overflow;
   } rsp_type;

   // Saturate cost + 1
   function automatic logic [CostWidth-1:0] cost_inc(input logic [CostWidth-1:0] c);
      cost_inc = (c == CostMax) ? CostMax : c + 1'b1;
   endfunction

endpackage

[rtl/hndv_if.sv]
// Valid/ready channel interface carrying one payload.
interface hndv_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/hndv_route_mem.sv]
// Route store: one entry per neighbor slot and route index, registered read.
module hndv_route_mem
   import hndv_pkg::*;
#(
   parameter int unsigned Depth = DefMaxNeighbors * DefMaxRoutes
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [HostWidth-1:0]     wr_dest,
   input  logic [CostWidth-1:0]     wr_cost,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [HostWidth-1:0]     rd_dest,
   output logic [CostWidth-1:0]     rd_cost
);

   logic [HostWidth+CostWidth-1:0] mem [Depth];
   logic [HostWidth+CostWidth-1:0] rd_ff;

   // Write one word, read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_dest, wr_cost};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_dest = rd_ff[HostWidth+CostWidth-1:CostWidth];
   assign rd_cost = rd_ff[CostWidth-1:0];

endmodule

[rtl/hello_neighbor_distance_vector_table.sv]
// Top level of the hello neighbor discovery and distance vector route table.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | operation, host, cost
//  rsp     | out | valid/ready  | route_found .. overflow
//  csr     | in  | write enable | index, data (no read-back)
//
// Header, listed, route, search and unused-code requests go from acceptance straight to the response.
// Tick and end walk the neighbor slots one per cycle;
// end also copies the staged routes, one per cycle, when the sender listed this host.
// A query walks every stored route, one memory read per cycle, through one
// shared compare unit.
// Reset is synchronous and clears control state; the route store needs no clearing.
// req_ready is low from acceptance until the response has been taken.
module hello_neighbor_distance_vector_table
   import hndv_pkg::*;
#(
   parameter int unsigned MAX_NEIGHBORS = DefMaxNeighbors,
   parameter int unsigned MAX_ROUTES    = DefMaxRoutes
) (
   input  logic                      clock,
   input  logic                      reset,
   hndv_if.sink                      req,
   hndv_if.source                    rsp,
   input  logic                      csr_write,
   input  logic [CsrIndexWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0]   csr_data
);

   localparam int unsigned NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int unsigned RW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
   localparam int unsigned CW = $clog2(MAX_ROUTES + 1);
   localparam int unsigned MD = MAX_NEIGHBORS * MAX_ROUTES;
   localparam int unsigned MW = $clog2(MD) > 0 ? $clog2(MD) : 1;
   localparam int unsigned NCW = $clog2(MAX_NEIGHBORS + 1);

   // Configuration registers
   logic [HostWidth-1:0]    this_host_ff;
   logic [TimeoutWidth-1:0] timeout_ff;
   logic [CountWidth-1:0]   target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         this_host_ff <= '0;
         timeout_ff   <= TimeoutReset;
         target_ff    <= TargetReset;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_THIS_HOST: this_host_ff <= csr_data[HostWidth-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data[TimeoutWidth-1:0];
            CSR_TARGET:    target_ff    <= csr_data[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // Neighbor table
   logic [MAX_NEIGHBORS-1:0] valid_ff, valid_in;
   logic [MAX_NEIGHBORS-1:0] bidir_ff, bidir_in;
   logic [HostWidth-1:0]     host_ff  [MAX_NEIGHBORS];
   logic [TimeWidth-1:0]     heard_ff [MAX_NEIGHBORS];
   logic [JoinWidth-1:0]     join_ff  [MAX_NEIGHBORS];
   logic [CW-1:0]            rcount_ff [MAX_NEIGHBORS];
   // Staging
   logic [HostWidth-1:0]     sdest_ff [MAX_ROUTES];
   logic [CostWidth-1:0]     scost_ff [MAX_ROUTES];
   logic [CW-1:0]            scount_ff, scount_in;
   logic [HostWidth-1:0]     sender_ff, sender_in;
   logic                     lists_ff, lists_in;
   logic [TimeWidth-1:0]     now_ff, now_in;
   logic                     srch_ff, srch_in;
   logic [HostWidth-1:0]     target_host_ff, target_host_in;
   logic [TimeWidth-1:0]     started_ff, started_in;
   logic [JoinWidth-1:0]     jctr_ff, jctr_in;

   // Sequencer
   state_type                state_ff, state_in;
   req_type                  op_ff, op_in;
   logic [NW-1:0]            idx_ff, idx_in;
   logic [RW-1:0]            ridx_ff, ridx_in;
   logic [NW-1:0]            slot_ff, slot_in;
   logic                     hit_ff, hit_in;
   logic                     free_ff, free_in;
   logic [NW-1:0]            free_slot_ff, free_slot_in;
   logic                     ovf_ff, ovf_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [NW-1:0]            rd_slot_ff, rd_slot_in;
   logic                     found_ff, found_in;
   logic [CostWidth-1:0]     best_ff, best_in;
   logic [JoinWidth-1:0]     best_age_ff, best_age_in;
   logic [HostWidth-1:0]     hop_ff, hop_in;
   rsp_type                  rsp_in;

   // Route memory
   logic                     mwr;
   logic [MW-1:0]            mwaddr, mraddr;
   logic [HostWidth-1:0]     mwdest, mrdest;
   logic [CostWidth-1:0]     mwcost, mrcost;

   hndv_route_mem #(.Depth(MD)) u_mem (
      .clock   (clock),
      .wr_en   (mwr),
      .wr_addr (mwaddr),
      .wr_dest (mwdest),
      .wr_cost (mwcost),
      .rd_addr (mraddr),
      .rd_dest (mrdest),
      .rd_cost (mrcost)
   );

   // Per-entry writes decided by the sequencer
   logic                 ent_wr;
   logic [NW-1:0]        ent_slot;
   logic [HostWidth-1:0] ent_host;
   logic                 heard_wr;
   logic                 join_wr;
   logic                 rcnt_wr;
   logic [CW-1:0]        rcnt_val;
   logic                 clr_wr;
   logic                 stage_wr;

   // Counts and status over the table
   logic [NCW-1:0] nb_cnt, nu_cnt;
   always_comb begin
      nb_cnt = '0;
      nu_cnt = '0;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
         if (valid_ff[i] && bidir_ff[i]) nb_cnt = nb_cnt + 1'b1;
         if (valid_ff[i] && !bidir_ff[i]) nu_cnt = nu_cnt + 1'b1;
      end
   end

   logic [NCW:0]     total;
   logic [NCW-1:0]   nb_sat_src, nu_sat_src;
   assign nb_sat_src = nb_cnt;
   assign nu_sat_src = nu_cnt;
   assign total = {1'b0, nb_cnt} + {1'b0, nu_cnt};

   function automatic logic [CountWidth-1:0] sat4(input logic [NCW-1:0] v);
      logic [NCW+3:0] w;
      w = {4'd0, v};
      sat4 = (w > 15) ? 4'hF : w[CountWidth-1:0];
   endfunction

   // Shared compare unit: age check, host match and cost compare
   logic [TimeWidth-1:0] age_sec;
   logic                 aged_out;
   assign age_sec  = now_ff - heard_ff[idx_ff];
   assign aged_out = age_sec > {16'd0, timeout_ff};

   logic [JoinWidth-1:0] q_age;
   logic [CostWidth-1:0] q_cost;
   logic                 q_better;
   assign q_age    = jctr_ff - join_ff[rd_slot_ff];
   assign q_cost   = cost_inc(mrcost);
   assign q_better = !found_ff || (q_cost < best_ff) ||
                     (q_cost == best_ff && q_age > best_age_ff);

   // Route address: slot times route depth plus route index
   assign mraddr = MW'(idx_ff) * MW'(MAX_ROUTES) + MW'(ridx_ff);
   assign mwaddr = MW'(slot_ff) * MW'(MAX_ROUTES) + MW'(ridx_ff);
   assign mwdest = sdest_ff[ridx_ff];
   assign mwcost = scost_ff[ridx_ff];

   logic last_idx, last_ridx;
   assign last_idx  = (idx_ff == NW'(MAX_NEIGHBORS - 1));
   assign last_ridx = (ridx_ff == RW'(MAX_ROUTES - 1));

   // Next state and datapath control
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      ridx_in        = ridx_ff;
      slot_in        = slot_ff;
      hit_in         = hit_ff;
      free_in        = free_ff;
      free_slot_in   = free_slot_ff;
      ovf_in         = ovf_ff;
      rd_pend_in     = 1'b0;
      rd_slot_in     = idx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_age_in    = best_age_ff;
      hop_in         = hop_ff;
      valid_in       = valid_ff;
      bidir_in       = bidir_ff;
      scount_in      = scount_ff;
      sender_in      = sender_ff;
      lists_in       = lists_ff;
      now_in         = now_ff;
      srch_in        = srch_ff;
      target_host_in = target_host_ff;
      started_in     = started_ff;
      jctr_in        = jctr_ff;
      mwr            = 1'b0;
      ent_wr         = 1'b0;
      ent_slot       = slot_ff;
      ent_host       = sender_ff;
      heard_wr       = 1'b0;
      join_wr        = 1'b0;
      rcnt_wr        = 1'b0;
      rcnt_val       = '0;
      clr_wr         = 1'b0;
      stage_wr       = 1'b0;
      req.ready      = 1'b0;
      rsp.valid      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               op_in    = req.payload;
               idx_in   = '0;
               ridx_in  = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               ovf_in   = 1'b0;
               found_in = 1'b0;
               best_in  = '0;
               best_age_in = '0;
               hop_in   = '0;
               state_in = ST_RESULT;
               case (op_type'(req.payload.operation))
                  OP_HEADER: begin
                     sender_in = req.payload.host;
                     lists_in  = 1'b0;
                     scount_in = '0;
                  end
                  OP_LISTED: begin
                     if (req.payload.host == this_host_ff) lists_in = 1'b1;
                  end
                  OP_ROUTE: begin
                     if (scount_ff < CW'(MAX_ROUTES)) begin
                        stage_wr  = 1'b1;
                        scount_in = scount_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_END: begin
                     if (sender_ff == target_host_ff) srch_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_TICK: begin
                     now_in   = now_ff + 1'b1;
                     state_in = ST_SCAN;
                  end
                  OP_SEARCH: begin
                     target_host_in = req.payload.host;
                     srch_in        = 1'b1;
                     started_in     = now_ff;
                  end
                  OP_QUERY: begin
                     if (req.payload.host == this_host_ff) begin
                        found_in = 1'b1;
                        hop_in   = this_host_ff;
                     end else begin
                        state_in = ST_QUERY;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Walk neighbor slots: find sender and free slot, or expire neighbors and a timed-out search on tick
         ST_SCAN: begin
            if (op_type'(op_ff.operation) == OP_TICK) begin
               if (valid_ff[idx_ff] && aged_out) begin
                  valid_in[idx_ff] = 1'b0;
                  bidir_in[idx_ff] = 1'b0;
                  clr_wr = 1'b1;
               end
               if (last_idx) begin
                  if (srch_ff && (now_ff - started_ff) > {16'd0, timeout_ff})
                     srch_in = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (valid_ff[idx_ff] && host_ff[idx_ff] == sender_ff && !hit_ff) begin
                  hit_in  = 1'b1;
                  slot_in = idx_ff;
               end
               if (!valid_ff[idx_ff] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = idx_ff;
               end
               if (last_idx) begin
                  state_in = ST_COPY;
                  ridx_in  = '0;
                  if (!hit_in) begin
                     if (!free_in) begin
                        ovf_in   = 1'b1;
                        state_in = ST_RESULT;
                     end else begin
                        slot_in = free_slot_in;
                     end
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // Update the entry and, if the sender listed this host, copy staged routes one per cycle
         ST_COPY: begin
            if (!lists_ff) begin
               valid_in[slot_ff] = 1'b1;
               bidir_in[slot_ff] = 1'b0;
               ent_wr   = !hit_ff;
               heard_wr = 1'b1;
               rcnt_wr  = 1'b1;
               rcnt_val = '0;
               state_in = ST_RESULT;
            end else begin
               if (ridx_ff == '0) begin
                  valid_in[slot_ff] = 1'b1;
                  ent_wr   = !hit_ff;
                  heard_wr = 1'b1;
                  if (!(hit_ff && bidir_ff[slot_ff])) begin
                     bidir_in[slot_ff] = 1'b1;
                     join_wr = 1'b1;
                     jctr_in = jctr_ff + 1'b1;
                  end
                  rcnt_wr  = 1'b1;
                  rcnt_val = scount_ff;
               end
               if (CW'(ridx_ff) < scount_ff) mwr = 1'b1;
               if (CW'(ridx_ff) + 1'b1 >= scount_ff || last_ridx) begin
                  state_in = ST_RESULT;
               end else begin
                  ridx_in = ridx_ff + 1'b1;
               end
            end
         end

         // Read each stored route once; compare the previous read
         ST_QUERY: begin
            if (rd_pend_ff && mrdest == op_ff.host && q_better) begin
               found_in    = 1'b1;
               best_in     = q_cost;
               best_age_in = q_age;
               hop_in      = host_ff[rd_slot_ff];
            end
            if (hit_ff) begin
               // read pipeline drained
               state_in = ST_RESULT;
            end else begin
               rd_pend_in = valid_ff[idx_ff] && bidir_ff[idx_ff] &&
                            (CW'(ridx_ff) < rcount_ff[idx_ff]);
               rd_slot_in = idx_ff;
               if (last_ridx || !rd_pend_in) begin
                  ridx_in = '0;
                  if (last_idx) hit_in = 1'b1;
                  else idx_in = idx_ff + 1'b1;
               end else begin
                  ridx_in = ridx_ff + 1'b1;
               end
            end
         end

         // Hold the response until taken
         ST_RESULT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // Status sampled from the state at the response
      rsp_in.route_found   = found_ff;
      rsp_in.next_hop      = found_ff ? hop_ff : '0;
      rsp_in.route_cost    = found_ff ? best_ff : '0;
      rsp_in.searching     = srch_ff;
      rsp_in.bidir_count   = sat4(nb_sat_src);
      rsp_in.unidir_count  = sat4(nu_sat_src);
      rsp_in.need_neighbor = ({{(CountWidth){1'b0}}, total} < {{(NCW+1){1'b0}}, target_ff})
                             && !srch_ff;
      rsp_in.overflow      = ovf_ff;
   end

   // Response payload is formed from settled state
   assign rsp.payload = rsp_in;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         bidir_ff       <= '0;
         scount_ff      <= '0;
         sender_ff      <= '0;
         lists_ff       <= 1'b0;
         now_ff         <= '0;
         srch_ff        <= 1'b0;
         target_host_ff <= '0;
         started_ff     <= '0;
         jctr_ff        <= '0;
         rd_pend_ff     <= 1'b0;
         for (int i = 0; i < MAX_NEIGHBORS; i++) rcount_ff[i] <= '0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         bidir_ff       <= bidir_in;
         scount_ff      <= scount_in;
         sender_ff      <= sender_in;
         lists_ff       <= lists_in;
         now_ff         <= now_in;
         srch_ff        <= srch_in;
         target_host_ff <= target_host_in;
         started_ff     <= started_in;
         jctr_ff        <= jctr_in;
         rd_pend_ff     <= rd_pend_in;
         if (clr_wr) rcount_ff[idx_ff] <= '0;
         if (rcnt_wr) rcount_ff[ent_slot] <= rcnt_val;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      ridx_ff      <= ridx_in;
      slot_ff      <= slot_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      ovf_ff       <= ovf_in;
      rd_slot_ff   <= rd_slot_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_age_ff  <= best_age_in;
      hop_ff       <= hop_in;
      if (ent_wr)   host_ff[ent_slot]  <= ent_host;
      if (heard_wr) heard_ff[ent_slot] <= now_ff;
      if (join_wr)  join_ff[ent_slot]  <= jctr_ff;
      if (stage_wr) begin
         sdest_ff[scount_ff[RW-1:0]] <= req.payload.host;
         scost_ff[scount_ff[RW-1:0]] <= req.payload.cost;
      end
   end

endmodule

[rtl/hndv_checker.sv]
// Port-level checker for the hello neighbor distance vector table, bound to the top level.
module hndv_checker
   import hndv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // No new request while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready during response");

   // An accepted request closes the input until answered
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");

   // Counts stay in table range
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.bidir_count + rsp_payload.unidir_count) <= 5'd8)
      else $error("neighbor count out of range");

   // A failed lookup reports zero hop and cost
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.route_found |->
         rsp_payload.next_hop == '0 && rsp_payload.route_cost == '0)
      else $error("stale route fields");

endmodule

bind hello_neighbor_distance_vector_table hndv_checker u_hndv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

[test/testbench.sv]
// Self-checking testbench for the hello neighbor distance vector table.
module testbench
   import hndv_pkg::*;
();

   localparam int Slots     = DefMaxNeighbors;
   localparam int Routes    = DefMaxRoutes;
   localparam int CycleLimit = 1500000;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   hndv_if #(.payload_type(req_type)) req_ch ();
   hndv_if #(.payload_type(rsp_type)) rsp_ch ();

   hello_neighbor_distance_vector_table dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Mirror of the neighbor table and its configuration
   bit [47:0] my_host;
   bit [15:0] age_limit;
   bit [3:0]  wanted;
   bit        nb_valid [Slots];
   bit        nb_bidir [Slots];
   bit [47:0] nb_host [Slots];
   bit [31:0] nb_heard [Slots];
   bit [15:0] nb_join [Slots];
   bit [47:0] nb_dest [Slots][Routes];
   bit [7:0]  nb_cost [Slots][Routes];
   int        nb_routes [Slots];
   bit [47:0] stage_dest [Routes];
   bit [7:0]  stage_cost [Routes];
   int        stage_n;
   bit [47:0] sender;
   bit        listed_me;
   bit [31:0] seconds;
   bit        search_on;
   bit [47:0] search_host;
   bit [31:0] search_t0;
   bit [15:0] join_ctr;

   rsp_type   expected_status [$];
   int        errors;
   int        items_sent;
   int        routes_found;
   int        overflows_seen;
   int        cycles = 0;
   int        send_idle_pct;
   int        recv_idle_pct;
   bit [47:0] host_pool [12];
   bit [47:0] dest_pool [10];

   // Clock and cycle limit
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench failed");
         $finish;
      end
   end

   function automatic void clear_table();
      for (int i = 0; i < Slots; i++) begin
         nb_valid[i] = 1'b0;
         nb_bidir[i] = 1'b0;
         nb_routes[i] = 0;
      end
      stage_n = 0;
      sender = '0;
      listed_me = 1'b0;
      seconds = '0;
      search_on = 1'b0;
      search_host = '0;
      search_t0 = '0;
      join_ctr = '0;
      my_host = '0;
      age_limit = TimeoutReset;
      wanted = TargetReset;
   endfunction

   // Close a hello: returns 1 when the newcomer found no free slot
   function automatic bit close_hello();
      int s;
      s = -1;
      for (int i = 0; i < Slots; i++)
         if (s < 0 && nb_valid[i] && nb_host[i] == sender) s = i;
      if (sender == search_host) search_on = 1'b0;
      if (s < 0) begin
         for (int i = 0; i < Slots; i++)
            if (s < 0 && !nb_valid[i]) s = i;
         if (s < 0) return 1'b1;
         nb_valid[s] = 1'b1;
         nb_bidir[s] = 1'b0;
         nb_host[s] = sender;
         nb_routes[s] = 0;
      end
      nb_heard[s] = seconds;
      if (listed_me) begin
         if (!nb_bidir[s]) begin
            nb_bidir[s] = 1'b1;
            nb_join[s] = join_ctr;
            join_ctr = join_ctr + 16'd1;
         end
         for (int k = 0; k < stage_n; k++) begin
            nb_dest[s][k] = stage_dest[k];
            nb_cost[s][k] = stage_cost[k];
         end
         nb_routes[s] = stage_n;
      end else begin
         nb_bidir[s] = 1'b0;
         nb_routes[s] = 0;
      end
      return 1'b0;
   endfunction

   // Advance one second and age out neighbors and the search
   function automatic void advance_second();
      bit [31:0] age;
      seconds = seconds + 32'd1;
      for (int i = 0; i < Slots; i++) begin
         age = seconds - nb_heard[i];
         if (nb_valid[i] && age > {16'd0, age_limit}) begin
            nb_valid[i] = 1'b0;
            nb_bidir[i] = 1'b0;
            nb_routes[i] = 0;
         end
      end
      age = seconds - search_t0;
      if (search_on && age > {16'd0, age_limit}) search_on = 1'b0;
   endfunction

   // Best route over bidirectional neighbors; oldest join wins a tie
   function automatic void lookup_route(input bit [47:0] dest, inout rsp_type r);
      bit [7:0]  best;
      bit [15:0] best_age;
      bit [15:0] age;
      bit [7:0]  c;
      bit        found;
      found = 1'b0;
      best = '0;
      best_age = '0;
      if (dest == my_host) begin
         r.route_found = 1'b1;
         r.next_hop = my_host;
         r.route_cost = '0;
         return;
      end
      for (int i = 0; i < Slots; i++) begin
         if (!nb_valid[i] || !nb_bidir[i]) continue;
         age = join_ctr - nb_join[i];
         for (int k = 0; k < nb_routes[i]; k++) begin
            if (nb_dest[i][k] != dest) continue;
            c = (nb_cost[i][k] == 8'hFF) ? 8'hFF : nb_cost[i][k] + 8'd1;
            if (!found || c < best || (c == best && age > best_age)) begin
               found = 1'b1;
               best = c;
               best_age = age;
               r.next_hop = nb_host[i];
            end
         end
      end
      r.route_found = found;
      r.route_cost = found ? best : 8'd0;
      if (!found) r.next_hop = '0;
   endfunction

   function automatic rsp_type table_predict(input req_type q);
      rsp_type r;
      int      nb;
      int      nu;
      r = '0;
      nb = 0;
      nu = 0;
      case (op_type'(q.operation))
         OP_HEADER: begin
            sender = q.host;
            listed_me = 1'b0;
            stage_n = 0;
         end
         OP_LISTED: if (q.host == my_host) listed_me = 1'b1;
         OP_ROUTE: begin
            if (stage_n < Routes) begin
               stage_dest[stage_n] = q.host;
               stage_cost[stage_n] = q.cost;
               stage_n++;
            end else begin
               r.overflow = 1'b1;
            end
         end
         OP_END: r.overflow = close_hello();
         OP_TICK: advance_second();
         OP_SEARCH: begin
            search_host = q.host;
            search_on = 1'b1;
            search_t0 = seconds;
         end
         OP_QUERY: lookup_route(q.host, r);
         default: ;
      endcase
      for (int i = 0; i < Slots; i++)
         if (nb_valid[i]) begin
            if (nb_bidir[i]) nb++;
            else nu++;
         end
      r.searching = search_on;
      r.bidir_count = 4'(nb);
      r.unidir_count = 4'(nu);
      r.need_neighbor = ((nb + nu) < wanted) && !search_on;
      return r;
   endfunction

   // Receiver stalls at random
   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void note_field(input string name, input bit [47:0] e, input bit [47:0] a);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %h, got %h", name, e, a);
   endfunction

   // Compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.payload;
         if (expected_status.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response with nothing expected: %p", a);
         end else begin
            e = expected_status.pop_front();
            if (a.route_found !== e.route_found)
               note_field("route_found", 48'(e.route_found), 48'(a.route_found));
            if (a.next_hop !== e.next_hop) note_field("next_hop", e.next_hop, a.next_hop);
            if (a.route_cost !== e.route_cost)
               note_field("route_cost", 48'(e.route_cost), 48'(a.route_cost));
            if (a.searching !== e.searching)
               note_field("searching", 48'(e.searching), 48'(a.searching));
            if (a.bidir_count !== e.bidir_count)
               note_field("bidir_count", 48'(e.bidir_count), 48'(a.bidir_count));
            if (a.unidir_count !== e.unidir_count)
               note_field("unidir_count", 48'(e.unidir_count), 48'(a.unidir_count));
            if (a.need_neighbor !== e.need_neighbor)
               note_field("need_neighbor", 48'(e.need_neighbor), 48'(a.need_neighbor));
            if (a.overflow !== e.overflow)
               note_field("overflow", 48'(e.overflow), 48'(a.overflow));
            if (e.route_found) routes_found++;
            if (e.overflow) overflows_seen++;
         end
      end
   end

   // Send one request and record its expected response at acceptance
   task automatic send_request(input op_type op, input bit [47:0] h, input bit [7:0] c);
      req_type q;
      q.operation = op;
      q.host = h;
      q.cost = c;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      do @(posedge clock); while (!req_ch.ready);
      expected_status = {expected_status, table_predict(q)};
      items_sent++;
   endtask

   // Hold off until every expected response has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input bit [47:0] value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_THIS_HOST: my_host = value;
         CSR_TIMEOUT:   age_limit = value[15:0];
         CSR_TARGET:    wanted = value[3:0];
         default: ;
      endcase
   endtask

   task automatic hello(input bit [47:0] from, input bit lists, input int n_routes,
                        input bit [7:0] cost_base);
      send_request(OP_HEADER, from, 8'($urandom));
      if (lists) send_request(OP_LISTED, my_host, 8'($urandom));
      for (int k = 0; k < n_routes; k++)
         send_request(OP_ROUTE, dest_pool[k % 10], 8'(cost_base + k));
      send_request(OP_END, 48'($urandom), 8'($urandom));
   endtask

   task automatic test_directed();
      bit [47:0] a;
      bit [47:0] b;
      a = 48'hFFFF_FFFF_FFFF;
      b = 48'h0000_0000_0001;
      write_reg(CSR_THIS_HOST, 48'h0);
      // lists this host, routes with saturating and zero cost
      send_request(OP_HEADER, a, 8'h00);
      send_request(OP_LISTED, 48'h0, 8'hFF);
      send_request(OP_ROUTE, dest_pool[0], 8'hFF);
      send_request(OP_ROUTE, dest_pool[1], 8'h00);
      send_request(OP_END, 48'h0, 8'h00);
      send_request(OP_QUERY, dest_pool[0], 8'h00);
      send_request(OP_QUERY, dest_pool[1], 8'h00);
      send_request(OP_QUERY, 48'h0, 8'h00);
      send_request(OP_QUERY, dest_pool[2], 8'h00);
      // second neighbor with a higher cost to the same destination: the first neighbor keeps the route
      hello(b, 1'b1, 2, 8'h00);
      send_request(OP_QUERY, dest_pool[1], 8'h00);
      // search, end without header, out-of-sequence items, unused code
      send_request(OP_SEARCH, b, 8'h00);
      send_request(OP_END, 48'h0, 8'h00);
      send_request(OP_ROUTE, dest_pool[3], 8'h80);
      send_request(OP_LISTED, a, 8'h00);
      send_request(OP_NONE, a, 8'hFF);
      send_request(OP_TICK, a, 8'hFF);
      send_request(OP_QUERY, a, 8'h00);
   endtask

   task automatic test_overflow();
      write_reg(CSR_TARGET, 48'd8);
      write_reg(CSR_THIS_HOST, host_pool[11]);
      // more senders than slots, the last one matching the search target
      send_request(OP_SEARCH, host_pool[8], 8'h00);
      for (int i = 0; i < 9; i++) hello(host_pool[i], i[0], 1, 8'h10);
      // staging overflow on an existing bidirectional neighbor
      hello(host_pool[1], 1'b1, 17, 8'hF0);
      send_request(OP_QUERY, dest_pool[6], 8'h00);
      // bidirectional stops listing, unidirectional starts listing
      hello(host_pool[1], 1'b0, 2, 8'h00);
      hello(host_pool[0], 1'b1, 3, 8'h05);
      send_request(OP_QUERY, dest_pool[2], 8'h00);
   endtask

   task automatic test_timeout();
      write_reg(CSR_TIMEOUT, 48'd1);
      send_request(OP_SEARCH, host_pool[10], 8'h00);
      repeat (3) send_request(OP_TICK, 48'h0, 8'h00);
      write_reg(CSR_TIMEOUT, 48'hFFFF);
      write_reg(CSR_TARGET, 48'd0);
      hello(host_pool[2], 1'b1, 1, 8'h00);
      repeat (3) send_request(OP_TICK, 48'h0, 8'h00);
   endtask

   // Mostly well-formed hellos with random content, plus ticks, queries, searches and noise
   task automatic random_traffic(input int n_items);
      int stop_at;
      int pick;
      bit paused;
      stop_at = items_sent + n_items;
      paused = 1'b0;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (!paused && items_sent > stop_at - n_items / 2) begin
            drain();
            paused = 1'b1;
         end
         if (pick < 45) begin
            hello(host_pool[$urandom_range(11)], $urandom_range(99) < 70,
                  ($urandom_range(19) == 0) ? 17 : $urandom_range(4), 8'($urandom));
         end else if (pick < 60) begin
            send_request(OP_TICK, 48'({$urandom, $urandom}), 8'($urandom));
         end else if (pick < 85) begin
            case ($urandom_range(3))
               0: send_request(OP_QUERY, my_host, 8'($urandom));
               1: send_request(OP_QUERY, 48'({$urandom, $urandom}), 8'($urandom));
               default: send_request(OP_QUERY, dest_pool[$urandom_range(9)], 8'($urandom));
            endcase
         end else if (pick < 90) begin
            send_request(OP_SEARCH, host_pool[$urandom_range(11)], 8'($urandom));
         end else begin
            send_request(op_type'($urandom_range(7)),
                         ($urandom_range(1) != 0) ? my_host : 48'({$urandom, $urandom}),
                         8'($urandom));
         end
      end
   endtask

   task automatic random_config(input bit [15:0] limit);
      write_reg(CSR_THIS_HOST, ($urandom_range(1) != 0) ? host_pool[$urandom_range(11)]
                                                        : 48'({$urandom, $urandom}));
      write_reg(CSR_TIMEOUT, 48'(limit));
      write_reg(CSR_TARGET, 48'($urandom_range(8)));
   endtask

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      errors = 0;
      items_sent = 0;
      routes_found = 0;
      overflows_seen = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      clear_table();
      foreach (host_pool[i]) host_pool[i] = 48'({$urandom, $urandom});
      foreach (dest_pool[i]) dest_pool[i] = 48'({$urandom, $urandom});
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      recv_idle_pct = 49;
      test_directed();
      test_overflow();
      test_timeout();
      random_config(16'd4);
      random_traffic(350);

      send_idle_pct = 49;
      recv_idle_pct = 32;
      random_config(16'd1);
      random_traffic(350);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_config(16'hFFFF);
      random_traffic(170);
      random_config(16'd6);
      random_traffic(170);

      drain();
      repeat (20) @(posedge clock);
      if (expected_status.size() != 0) errors++;
      $display("%0d requests sent over hellos, ticks, searches and queries;", items_sent);
      $display("%0d routes found, %0d overflow responses, %0d mismatches",
               routes_found, overflows_seen, errors);
      if (errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
